### rtl/cpm_pkg.sv
// Package for the cyclic polynomial multiplier modulo a prime.
// Holds the register index codes and the fixed width of the ring size register.
// Used by cyclic_poly_mulmod; depends on nothing.
package cpm_pkg;

    // Width of the ring size register.
    localparam int RING_W = 7;

    // Width of the register index on the configuration port.
    localparam int CFG_IDX_W = 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RING  = 1'b1;

endpackage

### rtl/cpm_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Used for the coefficient stores of cyclic_poly_mulmod; depends on nothing.
module cpm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cyclic_poly_mulmod.sv
// Cyclic convolution of two polynomials modulo a prime p and modulo X^m-1.
// Depends on cpm_pkg and on cpm_ram for the two coefficient stores.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+-------------------------
//  config    | cfg_wr_en, cfg_index, cfg_data               | write when cfg_wr_en high
//  request   | start, coef_index, a_coef, b_coef, last      | taken when start && !busy
//  result    | out_valid, out_index, out_coef, out_last     | one cycle per out_valid
//
// A request outside the ring and without last stores nothing and leaves the block idle.
// A request inside the ring keeps the block busy while the bit-serial modular multiplier
// reduces a_coef. A product runs m*m terms; each term passes the store read states S_RD
// and S_LOAD and then the shared bit-serial modular multiplier, and a product of ring size
// m ends with the final result strobe. Results come out one per m terms.
// Reset clears the valid bits of the stores at once; there is no clearing pass.
module cyclic_poly_mulmod #(
    parameter int MAX_RING  = 64,
    parameter int COEF_BITS = 31,
    localparam int IDX_W = (MAX_RING > 1) ? $clog2(MAX_RING) : 1,
    localparam int CFG_W = (COEF_BITS > cpm_pkg::RING_W) ? COEF_BITS : cpm_pkg::RING_W
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [IDX_W-1:0]              coef_index,
    input  logic [COEF_BITS-1:0]          a_coef,
    input  logic [COEF_BITS-1:0]          b_coef,
    input  logic                          last,
    output logic                          out_valid,
    output logic [IDX_W-1:0]              out_index,
    output logic [COEF_BITS-1:0]          out_coef,
    output logic                          out_last
);

    localparam int CNT_W = $clog2(MAX_RING + 1);
    localparam int EW    = (CNT_W > cpm_pkg::RING_W) ? CNT_W : cpm_pkg::RING_W;
    localparam logic [COEF_BITS-1:0] PRIME_RESET = COEF_BITS'(64'd2147483647);
    localparam logic [cpm_pkg::RING_W-1:0] RING_RESET = cpm_pkg::RING_W'(64);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [COEF_BITS-1:0]       prime_reg, prime_next;
    logic [cpm_pkg::RING_W-1:0] ring_reg, ring_next;
    logic [MAX_RING-1:0]        valid_reg, valid_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic                       last_reg, last_next;
    logic                       va_reg, va_next;
    logic                       vb_reg, vb_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg, out_last_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [COEF_BITS-1:0]       mx_reg, mx_next;
    logic [COEF_BITS-1:0]       my_reg, my_next;
    logic [COEF_BITS-1:0]       mr_reg, mr_next;
    logic [COEF_BITS-1:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]           out_index_reg, out_index_next;
    logic [COEF_BITS-1:0]       out_coef_reg, out_coef_next;

    logic [EW-1:0]        ring_ext;
    logic [EW-1:0]        max_ext;
    logic [EW-1:0]        m_wide;
    logic [CNT_W-1:0]     m_eff;
    logic [CNT_W-1:0]     m_last;
    logic [CNT_W-1:0]     k_ext;
    logic [CNT_W-1:0]     i_ext;
    logic [CNT_W-1:0]     j_full;
    logic [IDX_W-1:0]     j_idx;
    logic                 accept;
    logic                 in_ring;
    logic                 mul_done;
    logic [COEF_BITS:0]   p_ext;
    logic [COEF_BITS:0]   r_sum;
    logic [COEF_BITS:0]   r_diff;
    logic [COEF_BITS-1:0] r_add;
    logic [COEF_BITS:0]   x_sum;
    logic [COEF_BITS:0]   x_diff;
    logic [COEF_BITS-1:0] x_dbl;
    logic [COEF_BITS:0]   acc_full;
    logic [COEF_BITS:0]   acc_diff;
    logic [COEF_BITS-1:0] acc_sum;
    logic                 a_we;
    logic                 b_we;
    logic [COEF_BITS-1:0] a_rdata;
    logic [COEF_BITS-1:0] b_rdata;

    // Effective ring size: zero acts as one, anything above MAX_RING is clamped.
    assign ring_ext = EW'(ring_reg);
    assign max_ext  = EW'(MAX_RING);
    assign m_wide   = (ring_ext == '0) ? EW'(1) :
                      ((ring_ext > max_ext) ? max_ext : ring_ext);
    assign m_eff    = m_wide[CNT_W-1:0];
    assign m_last   = m_eff - CNT_W'(1);

    // Partner index j = (k - i) mod m, so that term i of result k is a[i] * b[j].
    // The sum may wrap in CNT_W bits; the true result is below m and comes out right.
    assign k_ext  = CNT_W'(k_reg);
    assign i_ext  = CNT_W'(i_reg);
    assign j_full = (k_ext >= i_ext) ? (k_ext - i_ext) : (k_ext + m_eff - i_ext);
    assign j_idx  = j_full[IDX_W-1:0];

    assign busy    = (state_reg != S_IDLE) || out_valid_reg;
    assign accept  = start && !busy;
    assign in_ring = CNT_W'(coef_index) < m_eff;

    // Shared bit-serial modular multiplier: r += x when the low bit of y is set,
    // x doubles mod p, y shifts right. Both adds work in parallel on registered values.
    assign mul_done = (my_reg == '0);
    assign p_ext    = {1'b0, prime_reg};
    assign r_sum    = {1'b0, mr_reg} + {1'b0, mx_reg};
    assign r_diff   = r_sum - p_ext;
    assign r_add    = (r_sum >= p_ext) ? r_diff[COEF_BITS-1:0] : r_sum[COEF_BITS-1:0];
    assign x_sum    = {1'b0, mx_reg} + {1'b0, mx_reg};
    assign x_diff   = x_sum - p_ext;
    assign x_dbl    = (x_sum >= p_ext) ? x_diff[COEF_BITS-1:0] : x_sum[COEF_BITS-1:0];
    assign acc_full = {1'b0, acc_reg} + {1'b0, mr_reg};
    assign acc_diff = acc_full - p_ext;
    assign acc_sum  = (acc_full >= p_ext) ? acc_diff[COEF_BITS-1:0]
                                          : acc_full[COEF_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        prime_next     = prime_reg;
        ring_next      = ring_reg;
        valid_next     = valid_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        last_next      = last_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        idx_next       = idx_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mr_next        = mr_reg;
        acc_next       = acc_reg;
        out_index_next = out_index_reg;
        out_coef_next  = out_coef_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                cpm_pkg::REG_PRIME: prime_next = cfg_data[COEF_BITS-1:0];
                cpm_pkg::REG_RING:  ring_next  = cfg_data[cpm_pkg::RING_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = coef_index;
                    last_next = last;
                    if (in_ring)
                    begin
                        // b is stored as it comes; the multiplier takes any b.
                        // a is reduced as 1 * a mod p before it is stored.
                        b_we                   = 1'b1;
                        valid_next[coef_index] = 1'b1;
                        mx_next                = COEF_BITS'(1);
                        my_next                = a_coef;
                        mr_next                = '0;
                        state_next             = S_RED;
                    end
                    else if (last)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RED:
            begin
                if (mul_done)
                begin
                    a_we = 1'b1;
                    if (last_reg)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    mr_next = my_reg[0] ? r_add : mr_reg;
                    mx_next = x_dbl;
                    my_next = my_reg >> 1;
                end
            end
            S_RD:
            begin
                va_next    = valid_reg[i_reg];
                vb_next    = valid_reg[j_idx];
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // Entries never written since the last product count as zero.
                mx_next    = va_reg ? a_rdata : '0;
                my_next    = vb_reg ? b_rdata : '0;
                mr_next    = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    if (CNT_W'(i_reg) == m_last)
                    begin
                        out_valid_next = 1'b1;
                        out_index_next = k_reg;
                        out_coef_next  = (prime_reg < COEF_BITS'(2)) ? '0 : acc_sum;
                        out_last_next  = (k_ext == m_last);
                        acc_next       = '0;
                        i_next         = '0;
                        if (k_ext == m_last)
                        begin
                            valid_next = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + IDX_W'(1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        acc_next   = acc_sum;
                        i_next     = i_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    mr_next = my_reg[0] ? r_add : mr_reg;
                    mx_next = x_dbl;
                    my_next = my_reg >> 1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prime_reg     <= PRIME_RESET;
            ring_reg      <= RING_RESET;
            valid_reg     <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            last_reg      <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prime_reg     <= prime_next;
            ring_reg      <= ring_next;
            valid_reg     <= valid_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            last_reg      <= last_next;
            va_reg        <= va_next;
            vb_reg        <= vb_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        mr_reg        <= mr_next;
        acc_reg       <= acc_next;
        out_index_reg <= out_index_next;
        out_coef_reg  <= out_coef_next;
    end

    cpm_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (MAX_RING)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (idx_reg),
        .wdata (mr_reg),
        .raddr (i_reg),
        .rdata (a_rdata)
    );

    cpm_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (MAX_RING)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (coef_index),
        .wdata (b_coef),
        .raddr (j_idx),
        .rdata (b_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_coef  = out_coef_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/cpm_checker.sv
// Port-level checker for cyclic_poly_mulmod, attached by the bind at the end.
// Watches the request and result ports only; depends on nothing else.
module cpm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last,
    input logic out_valid,
    input logic out_last
);

    // Results appear only while the block reports itself busy.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
        else $error("result strobe while not busy");

    // A request with last always starts a product.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> busy)
        else $error("last request did not start a product");

    assert property (@(posedge clk) disable iff (!rst_n) out_last |-> out_valid)
        else $error("out_last without a result strobe");

    // Each result needs at least one store read, so strobes never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> !out_valid)
        else $error("result strobes in consecutive cycles");

    // After the final result the block is ready for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |=> !busy)
        else $error("block still busy after the final result");

endmodule

bind cyclic_poly_mulmod cpm_checker u_cpm_checker (.*);
